>>> rtl/core/pose_velocity_estimator_core_defines.svh
// Assertion macros used by the pose velocity estimator core.
`ifndef POSE_VELOCITY_ESTIMATOR_CORE_DEFINES_SVH
`define POSE_VELOCITY_ESTIMATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PVE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PVE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pve_pkg.sv
// Types, constants and register codes for the pose velocity estimator.
`timescale 1ns / 1ps

package pve_pkg;

    // Defaults for the top-level parameters
    localparam int EPSILON_US_DEF       = 1;
    localparam int TICKS_PER_SECOND_DEF = 1000000;

    // Divisor width: 32-bit elapsed time plus an epsilon of up to 1000
    localparam int DEN_W = 33;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FIELD_WIDTH  = 1'b0;
    localparam logic REG_FIELD_HEIGHT = 1'b1;
    localparam logic [15:0] FIELD_WIDTH_RST  = 16'd1500;
    localparam logic [15:0] FIELD_HEIGHT_RST = 16'd1300;

    // Item opcodes
    localparam logic OPC_UPDATE = 1'b0;
    localparam logic OPC_CLEAR  = 1'b1;

    // Rate slots, worked through in this order
    localparam logic [1:0] SEL_X    = 2'd0;
    localparam logic [1:0] SEL_Y    = 2'd1;
    localparam logic [1:0] SEL_TURN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_COMMIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [15:0] width_mm;
        logic [15:0] height_mm;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/core/pve_cfg_regs.sv
// APB register file holding the field clamp bounds.
`timescale 1ns / 1ps

module pve_cfg_regs
    import pve_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [15:0] r_width;
    logic [15:0] r_height;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // Write the selected bound
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FIELD_WIDTH_RST;
            r_height <= FIELD_HEIGHT_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_FIELD_WIDTH:  r_width  <= pwdata[15:0];
                REG_FIELD_HEIGHT: r_height <= pwdata[15:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_FIELD_WIDTH:  prdata = {16'd0, r_width};
            REG_FIELD_HEIGHT: prdata = {16'd0, r_height};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.width_mm  = r_width;
    assign o_cfg.height_mm = r_height;

endmodule

>>> rtl/core/pve_divider.sv
// Iterative restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module pve_divider
    import pve_pkg::*;
#(
    parameter int DVD_W = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output t_div_stat        o_stat
);

    localparam int STEPS = (DVD_W + 1) / 2;
    localparam int QW    = 2 * STEPS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [QW-1:0]    r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_div;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [QW-1:0]    n_quo;
    logic [DEN_W:0]   n_rem;

    // Shift in two dividend bits and subtract where the divisor fits
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[DEN_W-1:0], n_quo[QW-1]};
            n_quo = {n_quo[QW-2:0], 1'b0};
            if (n_rem >= {1'b0, r_div}) begin
                n_rem    = n_rem - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
        end
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then advance the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= QW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_quo[DVD_W-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> rtl/core/pose_velocity_estimator_core.sv
// Pose velocity estimator: clamps pose samples and derives three saturated rates.
// Sequence: a clear item goes through EMIT to the output register, a first sample through COMMIT and EMIT.
// A sample with a previous one runs three divisions on one shared divider, each through the
// ABS, MUL, START and WAIT states, and then goes through COMMIT and EMIT.
// Throughput: one item at a time; input stall stays high until the result is registered.
// Reset (synchronous, active low) clears the stored pose, time and rates, reloads the bounds.
`timescale 1ns / 1ps
`include "pose_velocity_estimator_core_defines.svh"

module pose_velocity_estimator_core
    import pve_pkg::*;
#(
    parameter int EPSILON_US       = EPSILON_US_DEF,
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic signed [16:0] i_pos_x_in,
    input  logic signed [16:0] i_pos_y_in,
    input  logic signed [15:0] i_heading_in,
    input  logic [31:0]        i_time_us,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_pos_x,
    output logic [15:0]        o_pos_y,
    output logic signed [15:0] o_heading,
    output logic signed [31:0] o_speed_x,
    output logic signed [31:0] o_speed_y,
    output logic signed [31:0] o_turn_rate,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int TW = $clog2(TICKS_PER_SECOND + 1);
    localparam int MW = 16 + TW;
    localparam int SW = (MW > 33) ? MW : 33;

    t_cfg             w_cfg;
    t_div_stat        w_div_stat;
    logic [MW-1:0]    w_quo;

    t_state           r_state;
    t_state           n_state;
    logic             w_in_accept;
    logic             w_div_start;
    logic             w_out_load;

    logic             r_have_prev;
    logic [15:0]      r_prev_x;
    logic [15:0]      r_prev_y;
    logic [15:0]      r_prev_h;
    logic [31:0]      r_prev_t;
    logic signed [31:0] r_rate [3];

    logic [15:0]      r_cur_x;
    logic [15:0]      r_cur_y;
    logic [15:0]      r_cur_h;
    logic [31:0]      r_cur_t;
    logic [31:0]      r_elapsed;
    logic [1:0]       r_sel;
    logic             r_neg;
    logic [15:0]      r_abs;
    logic [MW-1:0]    r_mag;
    logic [DEN_W-1:0] r_den;

    logic             r_out_valid;
    logic [15:0]      r_out_x;
    logic [15:0]      r_out_y;
    logic [15:0]      r_out_h;
    logic [31:0]      r_out_sx;
    logic [31:0]      r_out_sy;
    logic [31:0]      r_out_st;

    logic [15:0]      w_clamp_x;
    logic [15:0]      w_clamp_y;
    logic [15:0]      w_dh;
    logic [16:0]      w_diff;
    logic [SW-1:0]    w_qx;
    logic [31:0]      w_sat;

    pve_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pve_divider #(
        .DVD_W (MW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_den),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    // Clamp incoming position to 0..bound
    always_comb begin
        if (i_pos_x_in[16]) begin
            w_clamp_x = '0;
        end else if (i_pos_x_in[15:0] > w_cfg.width_mm) begin
            w_clamp_x = w_cfg.width_mm;
        end else begin
            w_clamp_x = i_pos_x_in[15:0];
        end
        if (i_pos_y_in[16]) begin
            w_clamp_y = '0;
        end else if (i_pos_y_in[15:0] > w_cfg.height_mm) begin
            w_clamp_y = w_cfg.height_mm;
        end else begin
            w_clamp_y = i_pos_y_in[15:0];
        end
    end

    // Select the difference for the current rate slot; heading wraps at a full turn
    always_comb begin
        w_dh = r_cur_h - r_prev_h;
        unique case (r_sel)
            SEL_X:   w_diff = {1'b0, r_cur_x} - {1'b0, r_prev_x};
            SEL_Y:   w_diff = {1'b0, r_cur_y} - {1'b0, r_prev_y};
            default: w_diff = {w_dh[15], w_dh};
        endcase
    end

    // Apply sign and saturate the quotient to 32-bit signed
    always_comb begin
        w_qx = SW'(w_quo);
        if (r_neg) begin
            if (w_qx > SW'(32'h8000_0000)) begin
                w_sat = 32'h8000_0000;
            end else begin
                w_sat = (~w_qx[31:0]) + 32'd1;
            end
        end else begin
            if (w_qx > SW'(32'h7FFF_FFFF)) begin
                w_sat = 32'h7FFF_FFFF;
            end else begin
                w_sat = w_qx[31:0];
            end
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes
    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_in_accept = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                w_in_accept = i_in_valid;
                if (i_in_valid) begin
                    if (i_opcode == OPC_CLEAR) begin
                        n_state = ST_EMIT;
                    end else if (r_have_prev) begin
                        n_state = ST_ABS;
                    end else begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_ABS:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_START;
            ST_START: begin
                w_div_start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = (r_sel == SEL_TURN) ? ST_COMMIT : ST_ABS;
                end
            end
            ST_COMMIT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Stored pose, time and rates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_h    <= '0;
            r_prev_t    <= '0;
            r_rate[0]   <= '0;
            r_rate[1]   <= '0;
            r_rate[2]   <= '0;
        end else begin
            if (w_in_accept && i_opcode == OPC_CLEAR) begin
                r_have_prev <= 1'b0;
                r_rate[0]   <= '0;
                r_rate[1]   <= '0;
                r_rate[2]   <= '0;
            end
            if (r_state == ST_WAIT && w_div_stat.done) begin
                r_rate[r_sel] <= w_sat;
            end
            if (r_state == ST_COMMIT) begin
                r_have_prev <= 1'b1;
                r_prev_x    <= r_cur_x;
                r_prev_y    <= r_cur_y;
                r_prev_h    <= r_cur_h;
                r_prev_t    <= r_cur_t;
            end
        end
    end

    // Working registers of the current sample
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cur_x   <= w_clamp_x;
            r_cur_y   <= w_clamp_y;
            r_cur_h   <= i_heading_in;
            r_cur_t   <= i_time_us;
            r_elapsed <= i_time_us - r_prev_t;
            r_sel     <= SEL_X;
        end
        if (r_state == ST_ABS) begin
            r_neg <= w_diff[16];
            r_abs <= w_diff[16] ? 16'(-w_diff) : w_diff[15:0];
            r_den <= {1'b0, r_elapsed} + DEN_W'(EPSILON_US);
        end
        if (r_state == ST_MUL) begin
            r_mag <= MW'(r_abs) * MW'(TICKS_PER_SECOND);
        end
        if (r_state == ST_WAIT && w_div_stat.done) begin
            r_sel <= r_sel + 2'd1;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_x  <= r_prev_x;
            r_out_y  <= r_prev_y;
            r_out_h  <= r_prev_h;
            r_out_sx <= r_rate[0];
            r_out_sy <= r_rate[1];
            r_out_st <= r_rate[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_heading   = r_out_h;
    assign o_speed_x   = r_out_sx;
    assign o_speed_y   = r_out_sy;
    assign o_turn_rate = r_out_st;

    // Checks on the sequencer and divider hand-off, and on the clear item
    `PVE_ASSERT_NOW(a_div_done_in_wait, w_div_stat.done, r_state == ST_WAIT, "divider finished outside wait state")
    `PVE_ASSERT_NOW(a_div_start_idle, w_div_start, !w_div_stat.busy, "divider started while busy")
    `PVE_ASSERT_NEXT(a_clear_zeroes, w_in_accept && i_opcode == OPC_CLEAR, !r_have_prev && r_rate[0] == 32'sd0 && r_rate[1] == 32'sd0 && r_rate[2] == 32'sd0, "clear item left rates or history")

endmodule
